>>> sv/crls_pkg.sv
// Shared widths and register codes for the Cramer's rule solver.
package crls_pkg;

  localparam int DATA_W    = 32;
  localparam int QUOT_W    = 48;
  localparam int FRAC_W    = 16;
  localparam int UCNT_W    = 3;
  localparam int VIDX_W    = 2;
  localparam int MAX_N_DEF = 4;
  localparam int PADDR_W   = 3;

  // Register index as seen on paddr[2].
  localparam logic REG_UNKNOWN_COUNT = 1'b0;

endpackage

>>> sv/crls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/crls_div.sv
// Restoring divider: (num * 2^16) / den, signed Q31.16, truncated, saturated.
module crls_div import crls_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DATA_W-1:0]        num,
  input  logic [DATA_W-1:0]        den,
  output logic                     done,
  output logic [QUOT_W-1:0]        quot
);

  localparam int CNT_W = $clog2(QUOT_W + 1);
  localparam logic [QUOT_W-1:0] QMAX = {1'b0, {(QUOT_W-1){1'b1}}};

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [QUOT_W-1:0] dvd;
  logic [DATA_W-1:0] dsr;
  logic [DATA_W-1:0] rem;
  logic              neg;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [QUOT_W-1:0] qmag;
  logic [DATA_W-1:0] num_mag;
  logic [DATA_W-1:0] den_mag;

  always_comb begin
    rem_sh  = {rem, dvd[QUOT_W-1]};
    diff    = rem_sh - {1'b0, dsr};
    ge      = (rem_sh >= {1'b0, dsr});
    qmag    = {dvd[QUOT_W-2:0], ge};
    num_mag = num[DATA_W-1] ? (~num + 1'b1) : num;
    den_mag = den[DATA_W-1] ? (~den + 1'b1) : den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(QUOT_W);
        dvd <= {num_mag, {FRAC_W{1'b0}}};
        dsr <= den_mag;
        rem <= '0;
        neg <= num[DATA_W-1] ^ den[DATA_W-1];
      end else if (run) begin
        rem <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        dvd <= qmag;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
          // clamp the one positive overflow, +2^47
          if (neg) begin
            quot <= ~qmag + 1'b1;
          end else if (qmag[QUOT_W-1]) begin
            quot <= QMAX;
          end else begin
            quot <= qmag;
          end
        end
      end
    end
  end

endmodule

>>> sv/cramer_rule_linear_solver_top.sv
// Top level of the Cramer's rule solver: load, determinant engine, results.
//
//   channel  signals                                                        direction
//   -------  -------------------------------------------------------------  ---------
//   input    start, busy, value                                             in/out
//   result   done, var_index, numerator, denominator, quotient, no_solution, last  out
//   config   psel, penable, pwrite, paddr, pwdata, prdata, pready           in/out
//
// Items load at one per cycle while busy is low. The last constant of a
// matrix raises busy. Each determinant is division-free (Bird's method) on
// one shared 32x32 multiplier fed from the matrix and scratch memories:
// a copy into scratch plus (n-1) MAC passes, each step ending in a drain.
// N+1 determinants and N divisions (one quotient bit a cycle) follow, unless
// the main determinant is zero. Reset is synchronous and clears control
// state. Results cannot be stalled: done is one cycle.
module cramer_rule_linear_solver_top import crls_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [DATA_W-1:0]   value,
  output logic                done,
  output logic [VIDX_W-1:0]   var_index,
  output logic [DATA_W-1:0]   numerator,
  output logic [DATA_W-1:0]   denominator,
  output logic [QUOT_W-1:0]   quotient,
  output logic                no_solution,
  output logic                last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int IW = $clog2(MAX_N);
  localparam int CW = $clog2(MAX_N + 1);
  localparam int CD = 1 << (2 * IW);
  localparam int KD = 1 << IW;
  localparam int SD = 2 << (2 * IW);

  typedef enum logic [2:0] {
    ST_LOAD, ST_COPY, ST_MAC, ST_DRAIN, ST_DECIDE, ST_DIV
  } state_t;

  state_t state;

  logic [UCNT_W-1:0] unknown_count;
  logic [CW-1:0]     n_eff;
  logic [IW-1:0]     nm1;
  logic [3:0]        uc4;

  // load counters
  logic [IW-1:0] row;
  logic [CW-1:0] col;

  // sequencer counters
  logic [IW-1:0] r, c, k;
  logic [CW-1:0] it;
  logic          repl;
  logic [IW-1:0] var_i;

  logic [DATA_W-1:0] main_det;
  logic [DATA_W-1:0] det_y;
  logic [DATA_W-1:0] diag_sum;
  logic [DATA_W-1:0] diag_x;

  // pipeline tags
  logic          v1, cp1, first1, last1, rowend1;
  logic [IW-1:0] r1, c1, k1;
  logic          v2, first2, last2;
  logic [IW-1:0] r2, c2;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] acc_next;

  // memory ports
  logic              coeff_we;
  logic [2*IW-1:0]   coeff_raddr;
  logic [DATA_W-1:0] coeff_rd;
  logic              const_we;
  logic [DATA_W-1:0] const_rd;
  logic              scr_we;
  logic [2*IW:0]     scr_waddr;
  logic [DATA_W-1:0] scr_wdata;
  logic [2*IW:0]     scr_raddr;
  logic [DATA_W-1:0] scr_rd;

  logic [DATA_W-1:0] aval;
  logic [DATA_W-1:0] mu;
  logic [DATA_W-1:0] prod_c;

  logic              cfg_wr;
  logic              accept;
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_UNKNOWN_COUNT) ? DATA_W'(unknown_count) : '0;
  assign busy   = (state != ST_LOAD);
  assign accept = start & ~busy;

  always_comb begin
    uc4 = {1'b0, unknown_count};
    if (uc4 < 4'd2) begin
      n_eff = CW'(2);
    end else if (uc4 > 4'(MAX_N)) begin
      n_eff = CW'(MAX_N);
    end else begin
      n_eff = CW'(uc4);
    end
    nm1 = IW'(n_eff - CW'(1));
  end

  // memories
  assign coeff_we    = accept & (col != n_eff);
  assign const_we    = accept & (col == n_eff);
  assign coeff_raddr = {k, c};
  assign scr_raddr   = {~it[0], r, k};

  crls_ram #(.WIDTH(DATA_W), .DEPTH(CD)) u_coeff (
    .clk(clk), .we(coeff_we), .waddr({row, col[IW-1:0]}), .wdata(value),
    .raddr(coeff_raddr), .rdata(coeff_rd)
  );

  crls_ram #(.WIDTH(DATA_W), .DEPTH(KD)) u_const (
    .clk(clk), .we(const_we), .waddr(row), .wdata(value),
    .raddr(k), .rdata(const_rd)
  );

  crls_ram #(.WIDTH(DATA_W), .DEPTH(SD)) u_scratch (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rd)
  );

  // data stage: pick the column operand, form mu, multiply, accumulate, pick the scratch write
  always_comb begin
    aval     = (repl && (c1 == var_i)) ? const_rd : coeff_rd;
    mu       = first1 ? (~diag_sum + 1'b1) : scr_rd;
    prod_c   = mu * aval;
    acc_next = first2 ? prod : (acc + prod);
    if (v1 && cp1) begin
      scr_we    = 1'b1;
      scr_waddr = {1'b0, k1, c1};
      scr_wdata = aval;
    end else begin
      scr_we    = v2 & last2;
      scr_waddr = {it[0], r2, c2};
      scr_wdata = acc_next;
    end
  end

  crls_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(det_y), .den(main_det),
    .done(div_done), .quot(div_quot)
  );

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1      <= (state == ST_COPY) || (state == ST_MAC);
      cp1     <= (state == ST_COPY);
      r1      <= r;
      c1      <= c;
      k1      <= k;
      first1  <= (state == ST_MAC) && (k == r);
      last1   <= (k == nm1);
      rowend1 <= (c == nm1) && (k == nm1);
      v2      <= v1 & ~cp1;
      first2  <= first1;
      last2   <= last1;
      r2      <= r1;
      c2      <= c1;
      prod    <= prod_c;
      if (v2) begin
        acc <= acc_next;
        if (last2 && (r2 == '0) && (c2 == '0) && (it == CW'(n_eff - CW'(1)))) begin
          // result carries (-1)^(n-1)
          det_y <= n_eff[0] ? acc_next : (~acc_next + 1'b1);
        end
      end
      if (v1 && !cp1) begin
        if (first1) begin
          diag_x <= scr_rd;
        end
        if (rowend1) begin
          diag_sum <= diag_sum + (first1 ? scr_rd : diag_x);
        end
      end
      if (state == ST_DRAIN && !v1 && !v2) begin
        diag_sum <= '0;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      unknown_count <= UCNT_W'(2);
      row           <= '0;
      col           <= '0;
      main_det      <= '0;
      repl          <= 1'b0;
      var_i         <= '0;
      it            <= '0;
      r             <= '0;
      c             <= '0;
      k             <= '0;
      done          <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      if (cfg_wr && paddr[2] == REG_UNKNOWN_COUNT) begin
        unknown_count <= pwdata[UCNT_W-1:0];
        row           <= '0;
        col           <= '0;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (col == n_eff) begin
              col <= '0;
              if (row == nm1) begin
                row   <= '0;
                repl  <= 1'b0;
                it    <= '0;
                k     <= '0;
                c     <= '0;
                state <= ST_COPY;
              end else begin
                row <= row + 1'b1;
              end
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        ST_COPY: begin
          if (c != nm1) begin
            c <= c + 1'b1;
          end else begin
            c <= '0;
            if (k != nm1) begin
              k <= k + 1'b1;
            end else begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_MAC: begin
          if (k != nm1) begin
            k <= k + 1'b1;
          end else if (c != nm1) begin
            c <= c + 1'b1;
            k <= r;
          end else if (r != '0) begin
            r <= r - 1'b1;
            c <= '0;
            k <= r - 1'b1;
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            if (it == CW'(n_eff - CW'(1))) begin
              state <= ST_DECIDE;
            end else begin
              it    <= it + 1'b1;
              r     <= nm1;
              c     <= '0;
              k     <= nm1;
              state <= ST_MAC;
            end
          end
        end
        ST_DECIDE: begin
          if (!repl) begin
            main_det <= det_y;
            if (det_y == '0) begin
              done        <= 1'b1;
              var_index   <= '0;
              numerator   <= '0;
              denominator <= '0;
              quotient    <= '0;
              no_solution <= 1'b1;
              last        <= 1'b1;
              state       <= ST_LOAD;
            end else begin
              repl  <= 1'b1;
              var_i <= '0;
              it    <= '0;
              k     <= '0;
              c     <= '0;
              state <= ST_COPY;
            end
          end else begin
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            done        <= 1'b1;
            var_index   <= VIDX_W'(var_i);
            numerator   <= det_y;
            denominator <= main_det;
            quotient    <= div_quot;
            no_solution <= 1'b0;
            last        <= (var_i == nm1);
            if (var_i == nm1) begin
              repl  <= 1'b0;
              state <= ST_LOAD;
            end else begin
              var_i <= var_i + 1'b1;
              it    <= '0;
              k     <= '0;
              c     <= '0;
              state <= ST_COPY;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule
